### design/ipt_pkg.sv
// ipt_pkg: shared types and constants of the IPv4 prefix trie engine.
// Used by ipt_ctrl, ipt_datapath and ipv4_prefix_trie_engine.
`default_nettype none

package ipt_pkg;

    // Key and field widths fixed by the request format
    localparam int KEY_BITS       = 32;
    localparam int KIDX_W         = 5;
    localparam int LEN_W          = 6;
    localparam int NODE_COUNT_DEF = 4096;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DEL    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_BADLEN   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Node write operations on the current node
    typedef enum logic [2:0] {
        WOP_NONE,
        WOP_LINK,
        WOP_MARK,
        WOP_UNMARK,
        WOP_UNLINK
    } wop_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_A_RD,
        S_A_EVAL,
        S_A_CHK,
        S_A_ALLOC,
        S_A_LINK,
        S_A_MARK,
        S_D_RD,
        S_D_EVAL,
        S_D_UNMARK,
        S_D_UP,
        S_D_PAR,
        S_D_PEVAL,
        S_L_RD,
        S_L_EVAL,
        S_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;          // capture request, start at root
        logic    node_rd;       // read node memory
        logic    rd_path_addr;  // read address from path stack output
        logic    use_fresh;     // decide on memory output, not held node
        logic    node_ld;       // held node <= memory output
        logic    step;          // descend to child
        logic    path_wr;       // record child on path stack
        wop_t    wop;
        logic    alloc;         // take a free node
        logic    link_move;     // move to freshly linked node
        logic    push_up;       // free current node, go up one level
        logic    cur_from_path; // current node <= path stack output
        logic    hit_upd;       // note a marked node during lookup
        logic    set_code;
        status_t code;
        logic    resp;          // load the output word
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req;
        logic bad_len;
        logic d_eq_len;
        logic d_next_eq_len;
        logic d_eq_key;
        logic d_zero;
        logic child_zero;
        logic used;
        logic has_kid;
        logic full;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### design/ipv4_prefix_trie_engine.sv
// ipv4_prefix_trie_engine: longest prefix match trie over IPv4 keys.
// Use: one request word in on s_axis (tuser = request type, tdata = address
// and prefix length), one result word out on m_axis (status, hit, length).
// Requests: add a prefix, delete a prefix, look up the longest stored
// prefix covering an address. Nodes live in a single-port node memory;
// freed nodes return to a free stack and are reused first.
// Timing: one request at a time. Each trie level is a node memory read,
// then a decide step. An add that grows new nodes spends an allocate and a
// link step per new node, a delete a check, parent read and unlink step per
// pruned node. The node memory port and its registered read set the pace.
// The result word sits in an output register; the next request is taken
// while it waits. If m_axis stalls, a finished request holds in its
// response step until the output register frees.
// Reset: clears the root node and the allocation counters; no memory sweep
// is needed, the table is empty right after reset.
// Depends on ipt_pkg, ipt_ctrl and ipt_datapath.
`default_nettype none

module ipv4_prefix_trie_engine
    import ipt_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // addr[31:0], prefix_len[37:32], zeros
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // status[1:0], hit[2], match_len[8:3], zeros
);

    cmd_t             cmd;
    sts_t             sts;
    logic             in_fire;
    logic [1:0]       status;
    logic             hit;
    logic [LEN_W-1:0] match_len;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    ipt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ipt_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_type    (s_axis_tuser),
        .in_addr    (s_axis_tdata[31:0]),
        .in_len     (s_axis_tdata[37:32]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (status),
        .out_hit    (hit),
        .out_mlen   (match_len)
    );

    // Pack result word
    assign m_axis_tdata = {7'd0, match_len, hit, status};

endmodule

`default_nettype wire

### design/ipt_ctrl.sv
// ipt_ctrl: request sequencer of the prefix trie engine.
// Depends on ipt_pkg; drives ipt_datapath through cmd_t, watches sts_t.
`default_nettype none

module ipt_ctrl
    import ipt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    output logic      in_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wop    = WOP_NONE;
        cmd.code   = ST_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.req == REQ_LOOKUP)
                begin
                    state_next = S_L_RD;
                end
                else if (sts.req == REQ_NONE)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOTFOUND;
                    state_next   = S_RESP;
                end
                else if (sts.bad_len)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_BADLEN;
                    state_next   = S_RESP;
                end
                else if (sts.req == REQ_ADD)
                begin
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_D_RD;
                end
            end
            // Add: walk existing nodes
            S_A_RD:
            begin
                cmd.node_rd = 1'b1;
                state_next  = S_A_EVAL;
            end
            S_A_EVAL:
            begin
                cmd.use_fresh = 1'b1;
                cmd.node_ld   = 1'b1;
                priority if (sts.d_eq_len)
                begin
                    state_next = S_A_MARK;
                end
                else if (sts.child_zero)
                begin
                    state_next = S_A_CHK;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_A_CHK:
            begin
                if (sts.full)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_FULL;
                    state_next   = S_RESP;
                end
                else
                begin
                    state_next = S_A_ALLOC;
                end
            end
            // Add: grow the missing tail
            S_A_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_A_LINK;
            end
            S_A_LINK:
            begin
                cmd.wop       = WOP_LINK;
                cmd.link_move = 1'b1;
                state_next    = sts.d_next_eq_len ? S_A_MARK : S_A_ALLOC;
            end
            S_A_MARK:
            begin
                cmd.wop      = WOP_MARK;
                cmd.set_code = 1'b1;
                cmd.code     = ST_OK;
                state_next   = S_RESP;
            end
            // Delete: walk down, recording the path
            S_D_RD:
            begin
                cmd.node_rd = 1'b1;
                state_next  = S_D_EVAL;
            end
            S_D_EVAL:
            begin
                cmd.use_fresh = 1'b1;
                cmd.node_ld   = 1'b1;
                priority if (sts.d_eq_len)
                begin
                    if (sts.used)
                    begin
                        state_next = S_D_UNMARK;
                    end
                    else
                    begin
                        cmd.set_code = 1'b1;
                        cmd.code     = ST_NOTFOUND;
                        state_next   = S_RESP;
                    end
                end
                else if (sts.child_zero)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOTFOUND;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.step    = 1'b1;
                    cmd.path_wr = 1'b1;
                    state_next  = S_D_RD;
                end
            end
            S_D_UNMARK:
            begin
                cmd.wop      = WOP_UNMARK;
                cmd.set_code = 1'b1;
                cmd.code     = ST_OK;
                state_next   = S_D_UP;
            end
            // Delete: prune childless unmarked nodes upward
            S_D_UP:
            begin
                if (sts.d_zero || sts.has_kid || sts.used)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.push_up = 1'b1;
                    state_next  = S_D_PAR;
                end
            end
            S_D_PAR:
            begin
                cmd.node_rd       = 1'b1;
                cmd.rd_path_addr  = 1'b1;
                cmd.cur_from_path = 1'b1;
                state_next        = S_D_PEVAL;
            end
            S_D_PEVAL:
            begin
                cmd.use_fresh = 1'b1;
                cmd.wop       = WOP_UNLINK;
                state_next    = S_D_UP;
            end
            // Lookup
            S_L_RD:
            begin
                cmd.node_rd = 1'b1;
                state_next  = S_L_EVAL;
            end
            S_L_EVAL:
            begin
                cmd.use_fresh = 1'b1;
                cmd.hit_upd   = 1'b1;
                if (sts.d_eq_key || sts.child_zero)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_L_RD;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/ipt_datapath.sv
// ipt_datapath: node memory, free stack, path stack and walk registers.
// Depends on ipt_pkg; commanded by ipt_ctrl.
`default_nettype none

module ipt_datapath
    import ipt_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [1:0]          in_type,
    input  wire logic [KEY_BITS-1:0] in_addr,
    input  wire logic [LEN_W-1:0]    in_len,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [1:0]               out_status,
    output logic                     out_hit,
    output logic [LEN_W-1:0]         out_mlen
);

    localparam int NIDX   = $clog2(NODE_COUNT);
    localparam int NW     = 2 * NIDX + 1;
    localparam int CW     = NIDX + 2;
    localparam int PDEPTH = KEY_BITS + 1;

    // Request registers
    logic [KEY_BITS-1:0] key_reg;
    logic [LEN_W-1:0]    len_reg;
    req_t                type_reg;
    logic [NIDX-1:0]     cur_reg;
    logic [LEN_W-1:0]    d_reg;
    logic                found_reg;
    logic [LEN_W-1:0]    mlen_reg;
    status_t             code_reg;
    logic [NIDX-1:0]     prev_reg;

    // Held copy of the current node
    logic [NIDX-1:0] hk0_reg, hk1_reg;
    logic            hused_reg;

    // Root node in flip-flops
    logic [NIDX-1:0] rk0_reg, rk1_reg;
    logic            rused_reg;

    // Node memory, entry 0 unused (root above)
    logic [NW-1:0]   node_mem [NODE_COUNT];
    logic [NW-1:0]   node_q;
    logic            root_sel_reg;

    // Free stack
    logic [NIDX-1:0] free_mem [NODE_COUNT];
    logic [NIDX-1:0] fs_q;
    logic [NIDX:0]   free_top_reg;
    logic [NIDX:0]   next_unused_reg;
    logic            pop_reg;
    logic [NIDX-1:0] alloc_reg;

    // Path stack
    logic [NIDX-1:0] path_mem [PDEPTH];
    logic [NIDX-1:0] path_q;

    // Output word
    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic                out_hit_reg;
    logic [LEN_W-1:0]    out_mlen_reg;

    logic [NIDX-1:0]     f_k0, f_k1, v_k0, v_k1;
    logic                f_used, v_used;
    logic                key_bit;
    logic [NIDX-1:0]     child;
    logic [NIDX-1:0]     new_idx;
    logic [NIDX-1:0]     w_k0, w_k1;
    logic                w_used;
    logic                wr_en;
    logic [NIDX-1:0]     rd_addr;
    logic [CW-1:0]       need, avail;
    logic [LEN_W-1:0]    d_plus1;

    // Node view: fresh memory output or held copy
    always_comb
    begin
        f_k0   = root_sel_reg ? rk0_reg   : node_q[NIDX-1:0];
        f_k1   = root_sel_reg ? rk1_reg   : node_q[2*NIDX-1:NIDX];
        f_used = root_sel_reg ? rused_reg : node_q[NW-1];
        v_k0   = cmd.use_fresh ? f_k0   : hk0_reg;
        v_k1   = cmd.use_fresh ? f_k1   : hk1_reg;
        v_used = cmd.use_fresh ? f_used : hused_reg;
    end

    assign key_bit = key_reg[KIDX_W'(KEY_BITS - 1) - d_reg[KIDX_W-1:0]];
    assign child   = key_bit ? v_k1 : v_k0;
    assign new_idx = pop_reg ? fs_q : alloc_reg;
    assign rd_addr = cmd.rd_path_addr ? path_q : cur_reg;
    assign d_plus1 = d_reg + LEN_W'(1);

    // Node write data
    always_comb
    begin
        w_k0   = v_k0;
        w_k1   = v_k1;
        w_used = v_used;
        wr_en  = 1'b1;
        unique case (cmd.wop)
            WOP_LINK:
            begin
                if (key_bit)
                begin
                    w_k1 = new_idx;
                end
                else
                begin
                    w_k0 = new_idx;
                end
            end
            WOP_MARK:   w_used = 1'b1;
            WOP_UNMARK: w_used = 1'b0;
            WOP_UNLINK:
            begin
                if (v_k0 == prev_reg)
                begin
                    w_k0 = '0;
                end
                if (v_k1 == prev_reg)
                begin
                    w_k1 = '0;
                end
            end
            default:    wr_en = 1'b0;
        endcase
    end

    // Capacity check for the tail of an add
    assign need  = CW'(len_reg - d_reg);
    assign avail = CW'(free_top_reg) + (CW'(NODE_COUNT) - CW'(next_unused_reg));

    // Status to controller
    always_comb
    begin
        sts.req           = type_reg;
        sts.bad_len       = len_reg > LEN_W'(KEY_BITS);
        sts.d_eq_len      = d_reg == len_reg;
        sts.d_next_eq_len = d_plus1 == len_reg;
        sts.d_eq_key      = d_reg == LEN_W'(KEY_BITS);
        sts.d_zero        = d_reg == '0;
        sts.child_zero    = child == '0;
        sts.used          = v_used;
        sts.has_kid       = (v_k0 != '0) || (v_k1 != '0);
        sts.full          = need > avail;
        sts.out_free      = !out_valid_reg || out_ready;
    end

    // Node memory port and read register
    always_ff @(posedge clk)
    begin
        if (wr_en && cur_reg != '0)
        begin
            node_mem[cur_reg] <= {w_used, w_k1, w_k0};
        end
        if (cmd.node_rd)
        begin
            node_q <= node_mem[rd_addr];
        end
    end

    // Free stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.push_up && free_top_reg < (NIDX+1)'(NODE_COUNT))
        begin
            free_mem[free_top_reg[NIDX-1:0]] <= cur_reg;
        end
        if (cmd.alloc)
        begin
            fs_q <= free_mem[free_top_reg[NIDX-1:0] - NIDX'(1)];
        end
    end

    // Path stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            path_mem[0] <= '0;
        end
        else if (cmd.path_wr)
        begin
            path_mem[d_plus1] <= child;
        end
        if (cmd.push_up)
        begin
            path_q <= path_mem[d_reg - LEN_W'(1)];
        end
    end

    // Root node and allocation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk0_reg         <= '0;
            rk1_reg         <= '0;
            rused_reg       <= 1'b0;
            free_top_reg    <= '0;
            next_unused_reg <= (NIDX+1)'(1);
            root_sel_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en && cur_reg == '0)
            begin
                rk0_reg   <= w_k0;
                rk1_reg   <= w_k1;
                rused_reg <= w_used;
            end
            if (cmd.node_rd)
            begin
                root_sel_reg <= rd_addr == '0;
            end
            if (cmd.alloc)
            begin
                if (free_top_reg != '0)
                begin
                    free_top_reg <= free_top_reg - (NIDX+1)'(1);
                end
                else
                begin
                    next_unused_reg <= next_unused_reg + (NIDX+1)'(1);
                end
            end
            else if (cmd.push_up && free_top_reg < (NIDX+1)'(NODE_COUNT))
            begin
                free_top_reg <= free_top_reg + (NIDX+1)'(1);
            end
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= in_addr;
            len_reg   <= in_len;
            type_reg  <= req_t'(in_type);
            cur_reg   <= '0;
            d_reg     <= '0;
            found_reg <= 1'b0;
            mlen_reg  <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                cur_reg <= child;
                d_reg   <= d_plus1;
            end
            if (cmd.link_move)
            begin
                cur_reg <= new_idx;
                d_reg   <= d_plus1;
            end
            if (cmd.push_up)
            begin
                prev_reg <= cur_reg;
                d_reg    <= d_reg - LEN_W'(1);
            end
            if (cmd.cur_from_path)
            begin
                cur_reg <= path_q;
            end
            if (cmd.hit_upd && v_used)
            begin
                found_reg <= 1'b1;
                mlen_reg  <= d_reg;
            end
        end
        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.alloc)
        begin
            pop_reg   <= free_top_reg != '0;
            alloc_reg <= next_unused_reg[NIDX-1:0];
        end
        // Held node copy
        if (cmd.link_move)
        begin
            hk0_reg   <= '0;
            hk1_reg   <= '0;
            hused_reg <= 1'b0;
        end
        else if (cmd.wop == WOP_UNMARK || cmd.wop == WOP_UNLINK)
        begin
            hk0_reg   <= w_k0;
            hk1_reg   <= w_k1;
            hused_reg <= w_used;
        end
        else if (cmd.node_ld)
        begin
            hk0_reg   <= f_k0;
            hk1_reg   <= f_k1;
            hused_reg <= f_used;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.resp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            if (type_reg == REQ_LOOKUP)
            begin
                out_status_reg <= found_reg ? ST_OK : ST_NOTFOUND;
                out_hit_reg    <= found_reg;
                out_mlen_reg   <= found_reg ? mlen_reg : '0;
            end
            else
            begin
                out_status_reg <= code_reg;
                out_hit_reg    <= 1'b0;
                out_mlen_reg   <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_hit    = out_hit_reg;
    assign out_mlen   = out_mlen_reg;

endmodule

`default_nettype wire

### tb/trie_checker.sv
// trie_checker: watches both stream channels of the prefix trie engine,
// keeps its own software trie to predict each result word and compares.
// Depends on ipt_pkg.
`timescale 1ns / 1ps

module trie_checker
    import ipt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count,
    output int               full_count,
    output int               hit_count
);

    localparam int NODES = NODE_COUNT_DEF;

    // Laid out as the result word: status in the low bits
    typedef struct packed {
        logic [5:0] match_len;
        logic       hit;
        status_t    status;
    } answer_t;

    // Software trie
    int unsigned kid0 [NODES];
    int unsigned kid1 [NODES];
    bit          marked [NODES];
    int unsigned free_nodes [NODES];
    int unsigned free_top;
    int unsigned next_unused;
    answer_t     answer_q [$];

    function automatic int unsigned addr_bit(logic [31:0] a, int unsigned d);
        return a[31 - d];
    endfunction

    function automatic int unsigned child(int unsigned n, int unsigned b);
        return b ? kid1[n] : kid0[n];
    endfunction

    function automatic int unsigned take_node();
        int unsigned n;
        if (free_top > 0) begin
            free_top--;
            n = free_nodes[free_top];
        end
        else begin
            n = next_unused;
            next_unused++;
        end
        kid0[n] = 0;
        kid1[n] = 0;
        marked[n] = 0;
        return n;
    endfunction

    function automatic status_t insert_prefix(logic [31:0] a, int unsigned len);
        int unsigned n, d, c, avail;
        n = 0;
        d = 0;
        if (len > KEY_BITS)
            return ST_BADLEN;
        while (d < len) begin
            c = child(n, addr_bit(a, d));
            if (c == 0)
                break;
            n = c;
            d++;
        end
        avail = free_top + (next_unused <= NODES ? NODES - next_unused : 0);
        if (len - d > avail)
            return ST_FULL;
        while (d < len) begin
            c = take_node();
            if (addr_bit(a, d))
                kid1[n] = c;
            else
                kid0[n] = c;
            n = c;
            d++;
        end
        marked[n] = 1;
        return ST_OK;
    endfunction

    function automatic status_t remove_prefix(logic [31:0] a, int unsigned len);
        int unsigned path [33];
        int unsigned n, c, cur, par;
        n = 0;
        if (len > KEY_BITS)
            return ST_BADLEN;
        path[0] = 0;
        for (int unsigned d = 0; d < len; d++) begin
            c = child(n, addr_bit(a, d));
            if (c == 0)
                return ST_NOTFOUND;
            n = c;
            path[d + 1] = n;
        end
        if (!marked[n])
            return ST_NOTFOUND;
        marked[n] = 0;
        // prune childless unmarked nodes back toward the root
        for (int i = len; i >= 1; i--) begin
            cur = path[i];
            par = path[i - 1];
            if (kid0[cur] != 0 || kid1[cur] != 0 || marked[cur])
                break;
            if (kid0[par] == cur)
                kid0[par] = 0;
            if (kid1[par] == cur)
                kid1[par] = 0;
            if (free_top < NODES) begin
                free_nodes[free_top] = cur;
                free_top++;
            end
        end
        return ST_OK;
    endfunction

    function automatic answer_t longest_match(logic [31:0] a);
        answer_t r;
        int unsigned n, c;
        r = '{status: ST_NOTFOUND, hit: 1'b0, match_len: '0};
        n = 0;
        for (int unsigned d = 0; d <= KEY_BITS; d++) begin
            if (marked[n]) begin
                r.status = ST_OK;
                r.hit = 1'b1;
                r.match_len = 6'(d);
            end
            if (d == KEY_BITS)
                break;
            c = child(n, addr_bit(a, d));
            if (c == 0)
                break;
            n = c;
        end
        return r;
    endfunction

    function automatic answer_t predict(req_t rq, logic [31:0] a, int unsigned len);
        answer_t r;
        r = '{status: ST_NOTFOUND, hit: 1'b0, match_len: '0};
        case (rq)
            REQ_ADD:    r.status = insert_prefix(a, len);
            REQ_DEL:    r.status = remove_prefix(a, len);
            REQ_LOOKUP: r = longest_match(a);
            default:    ;
        endcase
        return r;
    endfunction

    assign pending_count = answer_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_w, got;
        if (!rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                kid0[i] = 0;
                kid1[i] = 0;
                marked[i] = 0;
            end
            free_top = 0;
            next_unused = 1;
            answer_q.delete();
            fail_count <= 0;
            result_count <= 0;
            full_count <= 0;
            hit_count <= 0;
        end
        else begin
            // output word first: it can only answer an earlier request
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[8:0];
                result_count <= result_count + 1;
                if (answer_q.size() == 0) begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else begin
                    exp_w = answer_q.pop_front();
                    if (got.status != exp_w.status || got.hit != exp_w.hit
                        || got.match_len != exp_w.match_len
                        || m_axis_tdata[15:9] != '0) begin
                        if (got.status != exp_w.status)
                            $error("status: expected %0d, got %0d", exp_w.status, got.status);
                        if (got.hit != exp_w.hit)
                            $error("hit: expected %0d, got %0d", exp_w.hit, got.hit);
                        if (got.match_len != exp_w.match_len)
                            $error("match_len: expected %0d, got %0d",
                                   exp_w.match_len, got.match_len);
                        if (m_axis_tdata[15:9] != '0)
                            $error("pad bits: expected 0, got %h", m_axis_tdata[15:9]);
                        fail_count <= fail_count + 1;
                    end
                    if (exp_w.status == ST_FULL)
                        full_count <= full_count + 1;
                    if (exp_w.hit)
                        hit_count <= hit_count + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                answer_q.push_back(predict(req_t'(s_axis_tuser), s_axis_tdata[31:0],
                                           s_axis_tdata[37:32]));
        end
    end

endmodule

### tb/testbench.sv
// testbench: stimulus and verdict for ipv4_prefix_trie_engine.
// Depends on ipt_pkg, the engine RTL and trie_checker.
`timescale 1ns / 1ps

module testbench;
    import ipt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // addr[31:0], prefix_len[37:32], zeros
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status[1:0], hit[2], match_len[8:3], zeros

    int  fail_count, pending_count, result_count, full_count, hit_count;
    int  words_sent;
    bit  calm;          // no idling in the final stretch
    bit  hold_sink;     // long receiver hold-off request
    logic [31:0] prefix_pool [16];

    ipv4_prefix_trie_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    trie_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .full_count    (full_count),
        .hit_count     (hit_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Present one request word and wait for its acceptance
    task automatic send_req(req_t rq, logic [31:0] a, logic [5:0] len);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq;
        s_axis_tdata  <= {2'b00, len, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic req_t pick_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return REQ_ADD;
        if (r < 65)
            return REQ_DEL;
        if (r < 98)
            return REQ_LOOKUP;
        return REQ_NONE;
    endfunction

    function automatic logic [5:0] pick_len(int deep);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 6'($urandom_range(33, 63));
        if (deep)
            return 6'($urandom_range(24, 32));
        return 6'($urandom_range(0, 32));
    endfunction

    initial
    begin
        logic [31:0] a;
        req_t        rq;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_NONE;
        calm = 1'b0;
        hold_sink = 1'b0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty lookup, extremes, bad lengths, re-add, absent delete
        send_req(REQ_LOOKUP, 32'h0000_0000, 6'd0);
        send_req(REQ_DEL,    32'h0000_0000, 6'd0);
        send_req(REQ_ADD,    32'hFFFF_FFFF, 6'd32);
        send_req(REQ_ADD,    32'hFFFF_FFFF, 6'd32);
        send_req(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd63);
        send_req(REQ_ADD,    32'h0000_0000, 6'd0);
        send_req(REQ_LOOKUP, 32'h1234_5678, 6'd0);
        send_req(REQ_ADD,    32'hC0A8_0000, 6'd16);
        send_req(REQ_LOOKUP, 32'hC0A8_0101, 6'd0);
        send_req(REQ_ADD,    32'h0A00_0000, 6'd33);
        send_req(REQ_DEL,    32'h0A00_0000, 6'd63);
        send_req(REQ_DEL,    32'hC0A8_0000, 6'd24);
        send_req(REQ_DEL,    32'hC0A8_0000, 6'd8);
        send_req(REQ_NONE,   32'hFFFF_FFFF, 6'd63);
        send_req(REQ_DEL,    32'hFFFF_FFFF, 6'd32);
        send_req(REQ_DEL,    32'hC0A8_0000, 6'd16);
        send_req(REQ_DEL,    32'h0000_0000, 6'd0);
        send_req(REQ_LOOKUP, 32'hC0A8_0101, 6'd0);
        send_req(REQ_ADD,    32'h8000_0000, 6'd1);
        send_req(REQ_LOOKUP, 32'h0000_0001, 6'd63);

        // Sender pause until every result is back
        drain();

        // Fill up: long deep adds with random tails exhaust the node memory
        for (int i = 0; i < 16; i++)
            prefix_pool[i] = $urandom();
        for (int i = 0; i < 200; i++)
            send_req(REQ_ADD, $urandom(), 6'd32);

        // Long receiver hold-off while requests keep coming
        hold_sink = 1'b1;
        for (int i = 0; i < 60; i++)
            send_req(REQ_LOOKUP, $urandom(), 6'($urandom()));

        // Free many nodes again, then mixed traffic around shared prefixes
        for (int i = 0; i < 1700; i++) begin
            if (i == 1450)
                calm = 1'b1;
            rq = pick_req();
            if ($urandom_range(0, 3) != 0)
                a = prefix_pool[$urandom_range(0, 15)] ^ ($urandom() >> $urandom_range(4, 32));
            else
                a = $urandom();
            if (rq == REQ_DEL && $urandom_range(0, 1))
                send_req(rq, a, 6'd32);
            else
                send_req(rq, a, pick_len($urandom_range(0, 1)));
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d requests, %0d results checked: %0d lookup hits, %0d table-full adds.",
                 words_sent, result_count, hit_count, full_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("timeout with %0d results outstanding", pending_count);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
